FILE: hw/rtl/cpq_pkg.sv
// ----------------------------------------------------------------------------
// cpq_pkg
// Shared types and codes for the circular playlist queue: command and status
// codes, the stored entry layout, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cpq_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int SEQ_W  = 16;
    localparam int ID_W   = 32;
    localparam int YEAR_W = 12;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd3;

    // sequence counter value after reset
    localparam logic [SEQ_W-1:0] SEQ_START = 16'd1;

    // one stored queue entry
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [ID_W-1:0]   song;
        logic [ID_W-1:0]   artist;
        logic [YEAR_W-1:0] year;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic              add_store;   // write input entry at tail, bump tail/count/seq
        logic              pop;         // advance head, decrement count
        logic              load_tail;   // start a one-entry walk at the tail slot
        logic              load_head;   // start a walk at the head slot
        logic              walk_all;    // walk covers every stored entry
        logic              rd_en;       // read memory at the walk pointer
        logic              emit_entry;  // load output from read data, step the walk
        logic              emit_blank;  // load a blank result with blank_status
        logic [STAT_W-1:0] blank_status;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic walk_last;  // current walk entry is the final one
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

FILE: hw/rtl/cpq_ctrl.sv
// ----------------------------------------------------------------------------
// cpq_ctrl
// Command sequencer: decodes an accepted transaction and steps the datapath
// through read/emit or blank phases until its last result has been registered.
// ----------------------------------------------------------------------------
module cpq_ctrl
    import cpq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_command,
    input  t_sts             i_sts,
    output t_cmd             o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_BLANK = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [STAT_W-1:0] r_blank, n_blank;
    logic              w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // state and blank status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_blank <= ST_OK;
        end else begin
            r_state <= n_state;
            r_blank <= n_blank;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_blank = r_blank;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_ADD) begin
                        if (i_sts.full) begin
                            n_blank = ST_FULL;
                            n_state = S_BLANK;
                        end else begin
                            o_cmd.add_store = 1'b1;
                            o_cmd.load_tail = 1'b1;
                            n_state         = S_READ;
                        end
                    end else if (i_sts.empty) begin
                        n_blank = ST_EMPTY;
                        n_state = S_BLANK;
                    end else begin
                        o_cmd.load_head = 1'b1;
                        o_cmd.pop       = (i_command == CMD_POP);
                        o_cmd.walk_all  = (i_command == CMD_DUMP);
                        n_state         = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    n_state          = i_sts.walk_last ? S_IDLE : S_READ;
                end
            end
            S_BLANK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_blank   = 1'b1;
                    o_cmd.blank_status = r_blank;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cpq_datapath.sv
// ----------------------------------------------------------------------------
// cpq_datapath
// Entry memory, head/tail pointers, entry count, sequence counter, walk
// pointer for reading results, and the registered output stage.
// ----------------------------------------------------------------------------
module cpq_datapath
    import cpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [ID_W-1:0]   i_song_id,
    input  logic [ID_W-1:0]   i_artist_id,
    input  logic [YEAR_W-1:0] i_release_year,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [SEQ_W-1:0]  o_entry_sequence,
    output logic [ID_W-1:0]   o_entry_song,
    output logic [ID_W-1:0]   o_entry_artist,
    output logic [YEAR_W-1:0] o_entry_year,
    output logic              o_last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd_data;
    logic [PTR_W-1:0]   r_head, r_tail, r_walk;
    logic [CNT_W-1:0]   r_count, r_walk_left;
    logic [SEQ_W-1:0]   r_next_seq;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    t_entry             r_out;
    logic               r_last;

    function automatic logic [PTR_W-1:0] f_step(input logic [PTR_W-1:0] p);
        return (p == PTR_MAX) ? '0 : p + PTR_W'(1);
    endfunction

    // status toward the controller
    assign o_sts.full      = (r_count == CNT_MAX);
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.walk_last = (r_walk_left == CNT_ONE);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_store) begin
            r_mem[r_tail] <= '{seq: r_next_seq, song: i_song_id,
                               artist: i_artist_id, year: i_release_year};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_walk];
        end
    end

    // queue pointers, count and sequence counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_next_seq <= SEQ_START;
        end else begin
            if (i_cmd.add_store) begin
                r_tail     <= f_step(r_tail);
                r_count    <= r_count + CNT_ONE;
                r_next_seq <= r_next_seq + SEQ_W'(1);
            end else if (i_cmd.pop) begin
                r_head  <= f_step(r_head);
                r_count <= r_count - CNT_ONE;
            end
        end
    end

    // walk pointer over the entries being returned
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk      <= '0;
            r_walk_left <= '0;
        end else if (i_cmd.load_tail) begin
            r_walk      <= r_tail;
            r_walk_left <= CNT_ONE;
        end else if (i_cmd.load_head) begin
            r_walk      <= r_head;
            r_walk_left <= i_cmd.walk_all ? r_count : CNT_ONE;
        end else if (i_cmd.emit_entry) begin
            r_walk      <= f_step(r_walk);
            r_walk_left <= r_walk_left - CNT_ONE;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_entry || i_cmd.emit_blank) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_entry) begin
            r_status <= ST_OK;
            r_out    <= r_rd_data;
            r_last   <= (r_walk_left == CNT_ONE);
        end else if (i_cmd.emit_blank) begin
            r_status <= i_cmd.blank_status;
            r_out    <= '0;
            r_last   <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_entry_sequence = r_out.seq;
    assign o_entry_song     = r_out.song;
    assign o_entry_artist   = r_out.artist;
    assign o_entry_year     = r_out.year;
    assign o_last           = r_last;

endmodule

FILE: hw/rtl/circular_playlist_queue.sv
// Steps: add, pop and peek pass acceptance, a memory read and an output load,
// which waits for a free output register; full or empty answers skip the read.
// A new command is taken only once the last result is loaded for output; a dump
// reads then loads each entry in turn through the single registered read port.
// Reset: synchronous, active low; clears pointers and count, sequence to 1.
// Entry storage is not cleared and holds data only once written.
// ----------------------------------------------------------------------------
// circular_playlist_queue
// Fixed-depth circular queue of playlist entries with add, pop, peek and dump
// commands, each entry stamped with a running 16-bit sequence number.
// ----------------------------------------------------------------------------
module circular_playlist_queue
    import cpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [ID_W-1:0]   i_song_id,
    input  logic [ID_W-1:0]   i_artist_id,
    input  logic [YEAR_W-1:0] i_release_year,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [SEQ_W-1:0]  o_entry_sequence,
    output logic [ID_W-1:0]   o_entry_song,
    output logic [ID_W-1:0]   o_entry_artist,
    output logic [YEAR_W-1:0] o_entry_year,
    output logic              o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    // command sequencer
    cpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // storage, pointers and output stage
    cpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_song_id        (i_song_id),
        .i_artist_id      (i_artist_id),
        .i_release_year   (i_release_year),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_entry_sequence (o_entry_sequence),
        .o_entry_song     (o_entry_song),
        .o_entry_artist   (o_entry_artist),
        .o_entry_year     (o_entry_year),
        .o_last           (o_last)
    );

endmodule
